@@ hw/rtl/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// Text console writer package
// Shared codes, command and result types for the text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  // Item kinds as they arrive on the input port.
  localparam logic [1:0] KIND_PUT = 2'd0;
  localparam logic [1:0] KIND_BS  = 2'd1;
  localparam logic [1:0] KIND_RD  = 2'd2;

  // Character that starts a new line, and the colour written by backspace.
  localparam logic [7:0] NL_CODE = 8'd10;
  localparam logic [7:0] BS_ATTR = 8'h0F;

  // Operations after classification by the front end.
  typedef enum logic [2:0] {
    OP_PUT,
    OP_NL,
    OP_BS,
    OP_RD,
    OP_NOP
  } tcw_op_e;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCROLL
  } tcw_state_e;

  // Classified command passed from the front end to the back end.
  typedef struct packed {
    tcw_op_e     op;
    logic [7:0]  char_code;
    logic [7:0]  attr;
    logic [10:0] read_index;
  } tcw_cmd_t;

  // One result beat.
  typedef struct packed {
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
  } tcw_res_t;

endpackage

`default_nettype wire

@@ hw/rtl/tcw_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
  parameter int Width = 16,
  parameter int Depth = 2000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/tcw_fifo.sv @@
// ----------------------------------------------------------------------------
// Small register queue
// A short first-in first-out queue built from flip-flops.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [Width-1:0] rdata_o,
  output logic                  empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/tcw_front.sv @@
// ----------------------------------------------------------------------------
// Text console writer front end
// Accepts input beats, classifies them and queues commands for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [1:0]        kind_i,
  input  wire logic [7:0]        char_code_i,
  input  wire logic [7:0]        attr_i,
  input  wire logic [10:0]       read_index_i,
  input  wire logic              init_busy_i,
  output tcw_pkg::tcw_cmd_t      cmd_o,
  output logic                   cmd_valid_o,
  input  wire logic              cmd_pop_i
);

  tcw_pkg::tcw_cmd_t cmd_in;
  logic              q_full;
  logic              q_empty;

  // Classify the incoming beat into one back-end operation.
  always_comb begin
    cmd_in.char_code  = char_code_i;
    cmd_in.attr       = attr_i;
    cmd_in.read_index = read_index_i;
    case (kind_i)
      tcw_pkg::KIND_PUT: begin
        cmd_in.op = (char_code_i == tcw_pkg::NL_CODE) ? tcw_pkg::OP_NL : tcw_pkg::OP_PUT;
      end
      tcw_pkg::KIND_BS: begin
        cmd_in.op = tcw_pkg::OP_BS;
      end
      tcw_pkg::KIND_RD: begin
        cmd_in.op = tcw_pkg::OP_RD;
      end
      default: begin
        cmd_in.op = tcw_pkg::OP_NOP;
      end
    endcase
  end

  // No beat is taken while the screen is being cleared after reset.
  assign full        = q_full || init_busy_i;
  assign cmd_valid_o = !q_empty;

  tcw_fifo #(
    .Width ($bits(tcw_pkg::tcw_cmd_t)),
    .Depth (2)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push && !full),
    .wdata_i (cmd_in),
    .full_o  (q_full),
    .pop_i   (cmd_pop_i),
    .rdata_o (cmd_o),
    .empty_o (q_empty)
  );

endmodule

`default_nettype wire

@@ hw/rtl/tcw_back.sv @@
// ----------------------------------------------------------------------------
// Text console writer back end
// Keeps the cursor and the screen memory and carries out queued commands.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_back #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tcw_pkg::tcw_cmd_t cmd_i,
  input  wire logic              cmd_valid_i,
  output logic                   cmd_pop_o,
  output logic                   init_busy_o,
  input  wire logic              res_full_i,
  output logic                   res_push_o,
  output tcw_pkg::tcw_res_t      res_o
);

  localparam int Cells = COLS * ROWS;
  localparam int AW    = $clog2(Cells);
  localparam int CW    = $clog2(COLS);
  localparam int RW    = $clog2(ROWS);
  localparam logic [AW:0]   CellsW  = (AW + 1)'(Cells);
  localparam logic [AW-1:0] ColsA   = AW'(COLS);
  localparam logic [AW-1:0] ColLenA = AW'(COLS - 1);
  localparam logic [AW-1:0] LastA   = AW'(Cells - 1);
  localparam logic [CW-1:0] ColLast = CW'(COLS - 1);
  localparam logic [RW-1:0] RowLast = RW'(ROWS - 1);

  // Sum of two in-range addresses folded back into the screen.
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= CellsW) begin
      sum = sum - CellsW;
    end
    return sum[AW-1:0];
  endfunction

  tcw_pkg::tcw_state_e state_q, state_d;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [AW-1:0] row_base_q, row_base_d;   // row times COLS, logical
  logic [AW-1:0] scr_base_q, scr_base_d;   // physical start of the top row
  logic [AW-1:0] clr_addr_q, clr_addr_d;
  logic [AW-1:0] clr_end_q, clr_end_d;

  logic          go;
  logic          do_nl;
  logic          rd_ok;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_wdata, ram_rdata;
  logic [AW-1:0] cur_lin;

  assign go      = (state_q == tcw_pkg::ST_IDLE) && cmd_valid_i && !res_full_i;
  assign rd_ok   = (32'(cmd_i.read_index) < 32'(Cells));
  assign do_nl   = go && ((cmd_i.op == tcw_pkg::OP_NL) ||
                          ((cmd_i.op == tcw_pkg::OP_PUT) && (col_q == ColLast)));
  assign cur_lin = row_base_q + AW'(col_q);
  assign init_busy_o = (state_q == tcw_pkg::ST_INIT);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      tcw_pkg::ST_INIT, tcw_pkg::ST_SCROLL: begin
        if (clr_addr_q == clr_end_q) begin
          state_d = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_READ: begin
        state_d = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_IDLE: begin
        if (go && (cmd_i.op == tcw_pkg::OP_RD) && rd_ok) begin
          state_d = tcw_pkg::ST_READ;
        end else if (do_nl && (row_q == RowLast)) begin
          state_d = tcw_pkg::ST_SCROLL;
        end
      end
      default: begin
        state_d = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath, memory accesses and result beats.
  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    row_base_d = row_base_q;
    scr_base_d = scr_base_q;
    clr_addr_d = clr_addr_q;
    clr_end_d  = clr_end_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = wrap_add(cur_lin, scr_base_q);
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = wrap_add(AW'(cmd_i.read_index), scr_base_q);

    case (state_q)
      tcw_pkg::ST_INIT, tcw_pkg::ST_SCROLL: begin
        ram_we     = 1'b1;
        ram_waddr  = clr_addr_q;
        clr_addr_d = clr_addr_q + 1'b1;
      end
      tcw_pkg::ST_READ: begin
        res_push_o = 1'b1;
      end
      tcw_pkg::ST_IDLE: begin
        if (go) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.op)
            tcw_pkg::OP_PUT: begin
              ram_we    = 1'b1;
              ram_wdata = {cmd_i.attr, cmd_i.char_code};
              if (col_q != ColLast) begin
                col_d = col_q + 1'b1;
              end
              res_push_o = 1'b1;
            end
            tcw_pkg::OP_BS: begin
              if (col_q != '0) begin
                col_d     = col_q - 1'b1;
                ram_we    = 1'b1;
                ram_waddr = wrap_add(cur_lin - 1'b1, scr_base_q);
                ram_wdata = {tcw_pkg::BS_ATTR, 8'd0};
              end
              res_push_o = 1'b1;
            end
            tcw_pkg::OP_RD: begin
              // An in-range read reports from the next cycle.
              ram_re     = rd_ok;
              res_push_o = !rd_ok;
            end
            default: begin
              res_push_o = 1'b1;
            end
          endcase
        end
      end
      default: begin
      end
    endcase

    // Newline: move down, or re-base the screen and clear the new bottom row.
    if (do_nl) begin
      col_d = '0;
      if (row_q == RowLast) begin
        scr_base_d = wrap_add(scr_base_q, ColsA);
        clr_addr_d = scr_base_q;
        clr_end_d  = scr_base_q + ColLenA;
      end else begin
        row_d      = row_q + 1'b1;
        row_base_d = row_base_q + ColsA;
      end
    end

    res_o.cursor_col = 7'(col_d);
    res_o.cursor_row = 5'(row_d);
    if (state_q == tcw_pkg::ST_READ) begin
      res_o.cell_char = ram_rdata[7:0];
      res_o.cell_attr = ram_rdata[15:8];
    end else begin
      res_o.cell_char = '0;
      res_o.cell_attr = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tcw_pkg::ST_INIT;
      col_q      <= '0;
      row_q      <= '0;
      row_base_q <= '0;
      scr_base_q <= '0;
      clr_addr_q <= '0;
      clr_end_q  <= LastA;
    end else begin
      state_q    <= state_d;
      col_q      <= col_d;
      row_q      <= row_d;
      row_base_q <= row_base_d;
      scr_base_q <= scr_base_d;
      clr_addr_q <= clr_addr_d;
      clr_end_q  <= clr_end_d;
    end
  end

  tcw_ram #(
    .Width (16),
    .Depth (Cells)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

@@ hw/rtl/text_console_writer_unit.sv @@
// Items pass the command queue, cell reads also the screen RAM read, then the result queue.
// Throughput: one item per cycle while results fit; an in-range read pauses the back end.
// A newline on the bottom row re-bases the screen and clears one row, stalling the back end.
// Reset: asynchronous, active low; afterwards full stays high while the screen memory
// is cleared one cell per cycle.
// ----------------------------------------------------------------------------
// Text console writer
// Character grid with cursor, newline, wrap, scroll, backspace and cell reads.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_unit #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  kind_i,
  input  wire logic [7:0]  char_code_i,
  input  wire logic [7:0]  attr_i,
  input  wire logic [10:0] read_index_i,
  output logic             empty,
  input  wire logic        pop,
  output logic      [6:0]  cursor_col_o,
  output logic      [4:0]  cursor_row_o,
  output logic      [7:0]  cell_char_o,
  output logic      [7:0]  cell_attr_o
);

  tcw_pkg::tcw_cmd_t cmd;
  tcw_pkg::tcw_res_t res_in;
  tcw_pkg::tcw_res_t res_out;
  logic              cmd_valid;
  logic              cmd_pop;
  logic              init_busy;
  logic              res_full;
  logic              res_push;

  tcw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .kind_i       (kind_i),
    .char_code_i  (char_code_i),
    .attr_i       (attr_i),
    .read_index_i (read_index_i),
    .init_busy_i  (init_busy),
    .cmd_o        (cmd),
    .cmd_valid_o  (cmd_valid),
    .cmd_pop_i    (cmd_pop)
  );

  tcw_back #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .init_busy_o (init_busy),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // Result queue decouples the back end from the consumer.
  tcw_fifo #(
    .Width ($bits(tcw_pkg::tcw_res_t)),
    .Depth (2)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_out),
    .empty_o (empty)
  );

  assign cursor_col_o = res_out.cursor_col;
  assign cursor_row_o = res_out.cursor_row;
  assign cell_char_o  = res_out.cell_char;
  assign cell_attr_o  = res_out.cell_attr;

endmodule

`default_nettype wire

@@ hw/rtl/tcw_checker.sv @@
// ----------------------------------------------------------------------------
// Text console writer checker
// Port-level assertions, attached to the top level by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_checker #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [6:0]  cursor_col_o,
  input wire logic [4:0]  cursor_row_o
);

  // A shown cursor column always lies on the screen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> ((COLS > 128) || (32'(cursor_col_o) < 32'(COLS))))
    else $error("cursor column beyond the last column");

  // A shown cursor row always lies on the screen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> ((ROWS > 32) || (32'(cursor_row_o) < 32'(ROWS))))
    else $error("cursor row beyond the last row");

  // The screen clear after reset keeps the input closed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> full)
    else $error("input open while the screen is still being cleared");

  // A waiting result beat stays put until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(cursor_col_o) && $stable(cursor_row_o)))
    else $error("waiting result changed before it was taken");

endmodule

bind text_console_writer_unit tcw_checker #(
  .COLS (COLS),
  .ROWS (ROWS)
) u_tcw_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .full         (full),
  .empty        (empty),
  .pop          (pop),
  .cursor_col_o (cursor_col_o),
  .cursor_row_o (cursor_row_o)
);

`default_nettype wire
